// ===== hdl/three_sorted_list_min_spread_macros.svh =====
// Assertion macros shared by the smallest-spread search block.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef THREE_SORTED_LIST_MIN_SPREAD_MACROS_SVH
`define THREE_SORTED_LIST_MIN_SPREAD_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TSLMS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define TSLMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TSLMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tslms_pkg.sv =====
// Shared types and constants of the smallest-spread search block.
// No dependencies; used by the subtractor unit and the top level.
package tslms_pkg;

   localparam int DATA_W    = 32;
   localparam int OPND_W    = DATA_W + 1;
   localparam int NUM_LISTS = 3;

   // Operation carried by the mode field of a request beat.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_START = 1'b1;

   // Flags and low bits of one pass through the shared subtractor.
   typedef struct packed {
      logic              neg;
      logic [DATA_W-1:0] diff;
   } sub_res_type;

endpackage

// ===== hdl/tslms_if.sv =====
// Handshake channels of the smallest-spread search block: request and response.
// Depends on nothing; both channels carry valid, ready and their payload.
interface tslms_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [1:0]         list_select;
   logic signed [31:0] element_value;

   modport source (output valid, mode, list_select, element_value, input ready);
   modport sink   (input valid, mode, list_select, element_value, output ready);
endinterface

interface tslms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_pick;
   logic signed [31:0] second_pick;
   logic signed [31:0] third_pick;
   logic [31:0]        spread;
   logic               found;

   modport source (output valid, first_pick, second_pick, third_pick, spread, found,
                   input ready);
   modport sink   (input valid, first_pick, second_pick, third_pick, spread, found,
                   output ready);
endinterface

// ===== hdl/tslms_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instantiated once per list by the top level.
module tslms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tslms_sub.sv =====
// Shared 33-bit subtractor of the search: every compare and the spread use it.
// Depends on tslms_pkg for the operand width and the result struct.
module tslms_sub (
   input  logic [tslms_pkg::OPND_W-1:0] op_a,
   input  logic [tslms_pkg::OPND_W-1:0] op_b,
   output tslms_pkg::sub_res_type       res
);

   logic [tslms_pkg::OPND_W:0] wide;

   // One guard bit keeps the sign exact for any pair of 33-bit operands.
   assign wide     = {op_a[tslms_pkg::OPND_W-1], op_a} - {op_b[tslms_pkg::OPND_W-1], op_b};
   assign res.neg  = wide[tslms_pkg::OPND_W];
   assign res.diff = wide[tslms_pkg::DATA_W-1:0];

endmodule

// ===== hdl/three_sorted_list_min_spread.sv =====
// Smallest-spread search over three ascending lists of signed 32-bit values. A request
// beat with mode 0 appends element_value to the list named by list_select (0, 1 or 2);
// it gives no response beat and is dropped when the list already holds LIST_DEPTH
// elements or the selector is 3. A request beat with mode 1 walks the lists with one
// head pointer each, keeps the earliest triple of heads whose spread (maximum minus
// minimum) is strictly smallest, always advances the pointer of the head that equals
// the minimum (first list, then second, then third), and stops as soon as any pointer
// reaches its list's count. It returns one response beat with the triple, its spread
// and found; found is 0 and all other fields are 0 when any list is empty. Handing
// over the result also empties all three lists. A walk step reads the three heads
// from registered RAM, then a single 33-bit subtractor performs all six compares and
// subtractions of the step one after another. The request side is not ready during
// the walk or while the finished search waits for the previous response beat to be
// taken. The response sits in an output register, so load beats are accepted while a
// finished result waits to be taken.
//
// Depends on tslms_pkg, tslms_if, tslms_ram, tslms_sub and the assertion macro header.
`include "three_sorted_list_min_spread_macros.svh"

module three_sorted_list_min_spread #(
   parameter int LIST_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   tslms_req_if.sink   req_bus,
   tslms_rsp_if.source rsp_bus
);

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);
   localparam int LAST = tslms_pkg::NUM_LISTS - 1;

   // Sequencer: one walk step is READ, HEADS, the four compare phases, DIFF and BEST.
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_READ  = 10'b00_0000_0010,
      ST_HEADS = 10'b00_0000_0100,
      ST_YLO   = 10'b00_0000_1000,
      ST_ZLO   = 10'b00_0001_0000,
      ST_YHI   = 10'b00_0010_0000,
      ST_ZHI   = 10'b00_0100_0000,
      ST_DIFF  = 10'b00_1000_0000,
      ST_BEST  = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Control state: list fill counts and the response flag.
   logic [CNT_W-1:0] cnt_ff [tslms_pkg::NUM_LISTS];
   logic [CNT_W-1:0] cnt_in [tslms_pkg::NUM_LISTS];
   logic             rsp_valid_ff, rsp_valid_in;

   // Walk state.
   logic [CNT_W-1:0]                  ptr_ff  [tslms_pkg::NUM_LISTS];
   logic [CNT_W-1:0]                  ptr_in  [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::DATA_W-1:0]      pick_ff [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::DATA_W-1:0]      pick_in [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::DATA_W-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [tslms_pkg::DATA_W-1:0]      diff_ff, diff_in;
   logic [tslms_pkg::DATA_W-1:0]      best_ff, best_in;
   logic                              have_ff, have_in;
   logic [1:0]                        min_idx_ff, min_idx_in;

   // Response payload registers.
   logic [tslms_pkg::DATA_W-1:0] rsp_pick_ff [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::DATA_W-1:0] rsp_pick_in [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::DATA_W-1:0] rsp_spread_ff, rsp_spread_in;
   logic                         rsp_found_ff, rsp_found_in;

   // Memories and the shared subtractor.
   logic                         wr_en [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::DATA_W-1:0] head  [tslms_pkg::NUM_LISTS];
   logic [tslms_pkg::OPND_W-1:0] sub_a, sub_b;
   tslms_pkg::sub_res_type       sub_res;
   logic                         req_fire;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Each list lives in its own RAM; a load writes at the current count, and the
   // read address always follows the list's head pointer.
   for (genvar g = 0; g < tslms_pkg::NUM_LISTS; g++) begin : g_list
      tslms_ram #(
         .WIDTH (tslms_pkg::DATA_W),
         .DEPTH (LIST_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (cnt_ff[g][ADDR_W-1:0]),
         .wr_data (req_bus.element_value),
         .rd_addr (ptr_ff[g][ADDR_W-1:0]),
         .rd_data (head[g])
      );
   end

   // Operand selection for the shared subtractor. Signed heads are sign-extended to
   // 33 bits; the unsigned spread compare zero-extends both sides.
   always_comb begin
      unique case (state_ff)
         ST_YLO: begin
            sub_a = {head[1][tslms_pkg::DATA_W-1], head[1]};
            sub_b = {lo_ff[tslms_pkg::DATA_W-1], lo_ff};
         end
         ST_ZLO: begin
            sub_a = {head[2][tslms_pkg::DATA_W-1], head[2]};
            sub_b = {lo_ff[tslms_pkg::DATA_W-1], lo_ff};
         end
         ST_YHI: begin
            sub_a = {hi_ff[tslms_pkg::DATA_W-1], hi_ff};
            sub_b = {head[1][tslms_pkg::DATA_W-1], head[1]};
         end
         ST_ZHI: begin
            sub_a = {hi_ff[tslms_pkg::DATA_W-1], hi_ff};
            sub_b = {head[2][tslms_pkg::DATA_W-1], head[2]};
         end
         ST_DIFF: begin
            sub_a = {hi_ff[tslms_pkg::DATA_W-1], hi_ff};
            sub_b = {lo_ff[tslms_pkg::DATA_W-1], lo_ff};
         end
         ST_BEST: begin
            sub_a = {1'b0, diff_ff};
            sub_b = {1'b0, best_ff};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   tslms_sub u_sub (
      .op_a (sub_a),
      .op_b (sub_b),
      .res  (sub_res)
   );

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      pick_in       = pick_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      diff_in       = diff_ff;
      best_in       = best_ff;
      have_in       = have_ff;
      min_idx_in    = min_idx_ff;
      rsp_pick_in   = rsp_pick_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      for (int i = 0; i < tslms_pkg::NUM_LISTS; i++) begin
         wr_en[i] = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.mode == tslms_pkg::MODE_START) begin
               // A fresh search: all heads at the front, nothing kept yet.
               for (int i = 0; i < tslms_pkg::NUM_LISTS; i++) begin
                  ptr_in[i]  = '0;
                  pick_in[i] = '0;
               end
               best_in  = '0;
               have_in  = 1'b0;
               state_in = ST_READ;
            end else if (req_fire) begin
               // A load into a full list or through the unused selector is dropped.
               for (int i = 0; i < tslms_pkg::NUM_LISTS; i++) begin
                  if (req_bus.list_select == 2'(i) && cnt_ff[i] != FULL_COUNT) begin
                     wr_en[i]  = 1'b1;
                     cnt_in[i] = cnt_ff[i] + CNT_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            // The walk ends as soon as any head runs off the end of its list.
            if (ptr_ff[0] >= cnt_ff[0] || ptr_ff[1] >= cnt_ff[1] ||
                ptr_ff[2] >= cnt_ff[2]) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_HEADS;
            end
         end
         ST_HEADS: begin
            lo_in      = head[0];
            hi_in      = head[0];
            min_idx_in = 2'd0;
            state_in   = ST_YLO;
         end
         ST_YLO: begin
            // Strict compares keep the earlier list as the one to advance on ties.
            if (sub_res.neg) begin
               lo_in      = head[1];
               min_idx_in = 2'd1;
            end
            state_in = ST_ZLO;
         end
         ST_ZLO: begin
            if (sub_res.neg) begin
               lo_in      = head[2];
               min_idx_in = 2'(LAST);
            end
            state_in = ST_YHI;
         end
         ST_YHI: begin
            if (sub_res.neg) begin
               hi_in = head[1];
            end
            state_in = ST_ZHI;
         end
         ST_ZHI: begin
            if (sub_res.neg) begin
               hi_in = head[2];
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Maximum minus minimum always fits 32 unsigned bits.
            diff_in  = sub_res.diff;
            state_in = ST_BEST;
         end
         ST_BEST: begin
            if (!have_ff || sub_res.neg) begin
               have_in = 1'b1;
               best_in = diff_ff;
               pick_in = head;
            end
            for (int i = 0; i < tslms_pkg::NUM_LISTS; i++) begin
               if (min_idx_ff == 2'(i)) begin
                  ptr_in[i] = ptr_ff[i] + CNT_W'(1);
               end
            end
            state_in = ST_READ;
         end
         ST_DONE: begin
            // Hand the result over once the output register is free, and empty the lists.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = pick_ff;
               rsp_spread_in = best_ff;
               rsp_found_in  = have_ff;
               for (int i = 0; i < tslms_pkg::NUM_LISTS; i++) begin
                  cnt_in[i] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tslms_pkg::NUM_LISTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pick_ff       <= pick_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      diff_ff       <= diff_in;
      best_ff       <= best_in;
      have_ff       <= have_in;
      min_idx_ff    <= min_idx_in;
      rsp_pick_ff   <= rsp_pick_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.first_pick  = rsp_pick_ff[0];
   assign rsp_bus.second_pick = rsp_pick_ff[1];
   assign rsp_bus.third_pick  = rsp_pick_ff[LAST];
   assign rsp_bus.spread      = rsp_spread_ff;
   assign rsp_bus.found       = rsp_found_ff;

   // A list never holds more elements than its RAM has entries.
   `TSLMS_ASSERT_ALWAYS(a_count_bound, clock, reset,
      cnt_ff[0] <= FULL_COUNT && cnt_ff[1] <= FULL_COUNT && cnt_ff[2] <= FULL_COUNT,
      "list count exceeds LIST_DEPTH")

   // During a walk no head pointer passes the end of its list.
   `TSLMS_ASSERT_SAME(a_ptr_bound, clock, reset, state_ff != ST_IDLE,
      ptr_ff[0] <= cnt_ff[0] && ptr_ff[1] <= cnt_ff[1] && ptr_ff[2] <= cnt_ff[2],
      "head pointer ran past its list count")

   // Handing over a result raises the response and empties every list.
   `TSLMS_ASSERT_NEXT(a_done_clears, clock, reset,
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready),
      rsp_valid_ff && cnt_ff[0] == '0 && cnt_ff[1] == '0 && cnt_ff[2] == '0,
      "finished search did not post a response and clear the lists")

   // Without a triple the response carries zeros.
   `TSLMS_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
      rsp_spread_ff == '0 && rsp_pick_ff[0] == '0 && rsp_pick_ff[1] == '0 &&
      rsp_pick_ff[2] == '0,
      "response without a triple carries nonzero fields")

endmodule
